// ===== src/telopt_pkg.sv =====
`timescale 1ns / 1ps

package telopt_pkg;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_LF   = 8'd10;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_NUL  = 8'd0;

    localparam logic [7:0] OPT_BIN     = 8'd0;
    localparam logic [7:0] OPTION_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA     = 8'd3;
    localparam logic [7:0] OPT_LM      = 8'd34;

    localparam logic [7:0] LM_MODE = 8'd1;
    localparam logic [7:0] LM_SLC  = 8'd3;
    localparam logic [7:0] SLC_ACKBIT = 8'd128;

    localparam logic [1:0] OK_REPLY = 2'd0;
    localparam logic [1:0] OK_ECHO  = 2'd1;
    localparam logic [1:0] OK_DATA  = 2'd2;
    localparam logic [1:0] OK_EOL   = 2'd3;

    localparam logic CFG_NEG_ENABLE = 1'b0;
    localparam logic CFG_ECHO_DFLT  = 1'b1;

    typedef enum logic [3:0] {
        ST_DATA      = 4'd0,
        ST_IAC       = 4'd1,
        ST_WILL      = 4'd2,
        ST_WONT      = 4'd3,
        ST_DO        = 4'd4,
        ST_DONT      = 4'd5,
        ST_SB        = 4'd6,
        ST_SB_LM     = 4'd7,
        ST_SKIP      = 4'd8,
        ST_SKIP_IAC  = 4'd9,
        ST_SLC_FUNC  = 4'd10,
        ST_SLC_IAC   = 4'd11,
        ST_SLC_MOD   = 4'd12,
        ST_SLC_VAL   = 4'd13,
        ST_MODE_MASK = 4'd14
    } parse_state_t;

    typedef enum logic [3:0] {
        JOB_DATA      = 4'd0,
        JOB_DATA_ECHO = 4'd1,
        JOB_EOL       = 4'd2,
        JOB_DO        = 4'd3,
        JOB_WILL      = 4'd4,
        JOB_WONT      = 4'd5,
        JOB_SLC_HDR   = 4'd6,
        JOB_SLC_TRIP  = 4'd7,
        JOB_SLC_END   = 4'd8,
        JOB_MODE      = 4'd9
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] arg;
    } job_t;

    typedef struct packed {
        logic bin;
        logic sga;
        logic lm;
        logic echo;
    } opt_flags_t;

    function automatic logic [2:0] job_len(job_kind_t kind);
        logic [2:0] len;
        len = 3'd1;
        unique case (kind)
            JOB_DATA_ECHO: len = 3'd2;
            JOB_DO, JOB_WILL, JOB_WONT, JOB_SLC_TRIP: len = 3'd3;
            JOB_SLC_HDR: len = 3'd4;
            JOB_SLC_END: len = 3'd2;
            JOB_MODE: len = 3'd7;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] job_byte(job_kind_t kind, logic [7:0] arg,
                                            logic [2:0] idx);
        logic [7:0] b;
        b = arg;
        unique case (kind)
            JOB_EOL: b = 8'd0;
            JOB_DO, JOB_WILL, JOB_WONT: begin
                if (idx == 3'd0) begin
                    b = B_IAC;
                end else if (idx == 3'd1) begin
                    b = (kind == JOB_DO) ? B_DO : ((kind == JOB_WILL) ? B_WILL : B_WONT);
                end else begin
                    b = arg;
                end
            end
            JOB_SLC_HDR: begin
                unique case (idx)
                    3'd0: b = B_IAC;
                    3'd1: b = B_SB;
                    3'd2: b = OPT_LM;
                    default: b = LM_SLC;
                endcase
            end
            JOB_SLC_TRIP: b = (idx == 3'd0) ? arg : 8'd0;
            JOB_SLC_END: b = (idx == 3'd0) ? B_IAC : B_SE;
            JOB_MODE: begin
                unique case (idx)
                    3'd0: b = B_IAC;
                    3'd1: b = B_SB;
                    3'd2: b = OPT_LM;
                    3'd3: b = LM_MODE;
                    3'd4: b = arg;
                    3'd5: b = B_IAC;
                    default: b = B_SE;
                endcase
            end
            default: b = arg;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] job_out_kind(job_kind_t kind, logic [2:0] idx);
        logic [1:0] k;
        k = OK_REPLY;
        unique case (kind)
            JOB_DATA: k = OK_DATA;
            JOB_DATA_ECHO: k = (idx == 3'd0) ? OK_DATA : OK_ECHO;
            JOB_EOL: k = OK_EOL;
            default: k = OK_REPLY;
        endcase
        return k;
    endfunction

endpackage

// ===== src/telopt_front.sv =====
`timescale 1ns / 1ps

module telopt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic                cfg_wr_data,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output logic                job_valid,
    output telopt_pkg::job_t    job
);

    logic                     neg_en_reg;
    logic                     echo_dflt_reg;
    telopt_pkg::parse_state_t state_reg, state_next;
    telopt_pkg::opt_flags_t   flags_reg, flags_next;
    logic [7:0]               slc_func_reg, slc_func_next;
    logic [7:0]               b;

    assign b = rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_en_reg    <= 1'b0;
            echo_dflt_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            if (cfg_index == telopt_pkg::CFG_NEG_ENABLE) begin
                neg_en_reg <= cfg_wr_data;
            end else begin
                echo_dflt_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= telopt_pkg::ST_DATA;
            flags_reg    <= '{bin: 1'b0, sga: 1'b1, lm: 1'b1, echo: 1'b0};
            slc_func_reg <= 8'd0;
        end else if (accept) begin
            state_reg    <= state_next;
            flags_reg    <= flags_next;
            slc_func_reg <= slc_func_next;
        end
    end

    always_comb begin
        state_next    = telopt_pkg::ST_DATA;
        flags_next    = flags_reg;
        slc_func_next = slc_func_reg;
        job_valid     = 1'b0;
        job.kind      = telopt_pkg::JOB_DATA;
        job.arg       = b;

        if (!neg_en_reg) begin
            state_next = telopt_pkg::ST_DATA;
            if (b == telopt_pkg::B_CR) begin
                job_valid = 1'b1;
                job.kind  = telopt_pkg::JOB_EOL;
            end else if (b != telopt_pkg::B_LF && b != telopt_pkg::B_NUL) begin
                job_valid = 1'b1;
                job.kind  = flags_reg.echo ? telopt_pkg::JOB_DATA_ECHO : telopt_pkg::JOB_DATA;
            end
        end else begin
            unique case (state_reg)
                telopt_pkg::ST_IAC: begin
                    if (b == telopt_pkg::B_WILL) begin
                        state_next = telopt_pkg::ST_WILL;
                    end else if (b == telopt_pkg::B_WONT) begin
                        state_next = telopt_pkg::ST_WONT;
                    end else if (b == telopt_pkg::B_DO) begin
                        state_next = telopt_pkg::ST_DO;
                    end else if (b == telopt_pkg::B_DONT) begin
                        state_next = telopt_pkg::ST_DONT;
                    end else if (b == telopt_pkg::B_SB) begin
                        state_next = telopt_pkg::ST_SB;
                    end
                end
                telopt_pkg::ST_WILL: begin
                    job.kind = telopt_pkg::JOB_DO;
                    if (b == telopt_pkg::OPT_BIN && !flags_reg.bin) begin
                        flags_next.bin = 1'b1;
                        job_valid      = 1'b1;
                    end else if (b == telopt_pkg::OPTION_ECHO && !flags_reg.echo) begin
                        flags_next.echo = 1'b1;
                        job_valid       = 1'b1;
                    end else if (b == telopt_pkg::OPT_SGA && !flags_reg.sga) begin
                        flags_next.sga = 1'b1;
                        job_valid      = 1'b1;
                    end else if (b == telopt_pkg::OPT_LM && !flags_reg.lm) begin
                        flags_next.lm = 1'b1;
                        job_valid     = 1'b1;
                    end
                end
                telopt_pkg::ST_WONT, telopt_pkg::ST_DONT: begin
                    if (b == telopt_pkg::OPT_BIN) begin
                        flags_next.bin = 1'b0;
                    end else if (b == telopt_pkg::OPT_LM) begin
                        flags_next.lm = 1'b0;
                        if (echo_dflt_reg) begin
                            flags_next.echo = 1'b1;
                        end
                    end else if (b == telopt_pkg::OPTION_ECHO &&
                                 state_reg == telopt_pkg::ST_WONT) begin
                        flags_next.echo = 1'b0;
                    end
                end
                telopt_pkg::ST_DO: begin
                    if (b == telopt_pkg::OPT_BIN) begin
                        flags_next.bin = 1'b1;
                        job_valid      = 1'b1;
                        job.kind       = telopt_pkg::JOB_WILL;
                    end else if (b == telopt_pkg::OPT_SGA) begin
                        flags_next.sga = 1'b1;
                        job_valid      = 1'b1;
                        job.kind       = telopt_pkg::JOB_WILL;
                    end else if (b != telopt_pkg::OPT_LM) begin
                        job_valid = 1'b1;
                        job.kind  = telopt_pkg::JOB_WONT;
                    end
                end
                telopt_pkg::ST_SB: begin
                    state_next = (b == telopt_pkg::OPT_LM) ? telopt_pkg::ST_SB_LM
                                                           : telopt_pkg::ST_SKIP;
                end
                telopt_pkg::ST_SB_LM: begin
                    if (b == telopt_pkg::LM_SLC) begin
                        job_valid  = 1'b1;
                        job.kind   = telopt_pkg::JOB_SLC_HDR;
                        state_next = telopt_pkg::ST_SLC_FUNC;
                    end else if (b == telopt_pkg::LM_MODE) begin
                        state_next = telopt_pkg::ST_MODE_MASK;
                    end else begin
                        state_next = telopt_pkg::ST_SKIP;
                    end
                end
                telopt_pkg::ST_SKIP: begin
                    state_next = (b == telopt_pkg::B_IAC) ? telopt_pkg::ST_SKIP_IAC
                                                          : telopt_pkg::ST_SKIP;
                end
                telopt_pkg::ST_SKIP_IAC: begin
                    if (b == telopt_pkg::B_SE) begin
                        state_next = telopt_pkg::ST_DATA;
                    end else if (b == telopt_pkg::B_IAC) begin
                        state_next = telopt_pkg::ST_SKIP_IAC;
                    end else begin
                        state_next = telopt_pkg::ST_SKIP;
                    end
                end
                telopt_pkg::ST_SLC_FUNC: begin
                    if (b == telopt_pkg::B_IAC) begin
                        state_next = telopt_pkg::ST_SLC_IAC;
                    end else begin
                        slc_func_next = b;
                        state_next    = telopt_pkg::ST_SLC_MOD;
                    end
                end
                telopt_pkg::ST_SLC_IAC, telopt_pkg::ST_SLC_MOD: begin
                    if (state_reg == telopt_pkg::ST_SLC_IAC && b == telopt_pkg::B_SE) begin
                        job_valid  = 1'b1;
                        job.kind   = telopt_pkg::JOB_SLC_END;
                        state_next = telopt_pkg::ST_DATA;
                    end else begin
                        if (state_reg == telopt_pkg::ST_SLC_IAC) begin
                            slc_func_next = telopt_pkg::B_IAC;
                        end
                        job.kind   = telopt_pkg::JOB_SLC_TRIP;
                        job.arg    = slc_func_next;
                        job_valid  = ((b & telopt_pkg::SLC_ACKBIT) == 8'd0) && (b[1:0] != 2'd0);
                        state_next = telopt_pkg::ST_SLC_VAL;
                    end
                end
                telopt_pkg::ST_SLC_VAL: begin
                    state_next = telopt_pkg::ST_SLC_FUNC;
                end
                telopt_pkg::ST_MODE_MASK: begin
                    job.kind   = telopt_pkg::JOB_MODE;
                    job_valid  = !b[0] || !b[1] || !b[2];
                    job.arg    = (!b[0] || !b[1]) ? (b | 8'd3) : (b | 8'd4);
                    state_next = telopt_pkg::ST_SKIP;
                end
                default: begin
                    if (b == telopt_pkg::B_IAC) begin
                        state_next = telopt_pkg::ST_IAC;
                    end else if (b == telopt_pkg::B_CR) begin
                        job_valid = 1'b1;
                        job.kind  = telopt_pkg::JOB_EOL;
                    end else if (b != telopt_pkg::B_LF && b != telopt_pkg::B_NUL) begin
                        job_valid = 1'b1;
                        job.kind  = flags_reg.echo ? telopt_pkg::JOB_DATA_ECHO
                                                   : telopt_pkg::JOB_DATA;
                    end
                end
            endcase
        end
    end

endmodule

// ===== src/telopt_queue.sv =====
`timescale 1ns / 1ps

module telopt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  telopt_pkg::job_t push_job,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output telopt_pkg::job_t head_job,
    output logic [1:0]       count
);

    telopt_pkg::job_t mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ===== src/telopt_back.sv =====
`timescale 1ns / 1ps

module telopt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  telopt_pkg::job_t head_job,
    output logic             pop,
    output logic [2:0]       idx,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_out_kind,
    output logic             m_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic       last_reg;
    logic [2:0] idx_reg, idx_next;
    logic       load;
    logic       item_last;

    assign load      = head_valid && (!valid_reg || m_ready);
    assign item_last = (idx_reg == (telopt_pkg::job_len(head_job.kind) - 3'd1));
    assign pop       = load && item_last;
    assign idx_next  = item_last ? 3'd0 : (idx_reg + 3'd1);
    assign idx       = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= telopt_pkg::job_byte(head_job.kind, head_job.arg, idx_reg);
            kind_reg <= telopt_pkg::job_out_kind(head_job.kind, idx_reg);
            last_reg <= item_last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_kind = kind_reg;
    assign m_last     = last_reg;

endmodule

// ===== src/telnet_option_negotiator_core.sv =====
`timescale 1ns / 1ps

// Telnet option negotiator. Takes one received byte per item on s_ and returns
// replies, echo, line data and end-of-line marks on m_, one result per item,
// with m_last on the final result of each input byte. The front parser takes
// a byte whenever its two-entry job queue has room, so bytes enter back to
// back; the back sequencer then sends one result per cycle from the head job
// while m_ready allows, so an input byte holds the output until all of its
// results (0 to 7, typically 1 or 2) are sent. Sustained rate is therefore
// set by the result count at the output register. Configuration writes take
// effect on the next cycle.
module telnet_option_negotiator_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_last
);

    logic             accept;
    logic             job_valid;
    telopt_pkg::job_t job;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;
    telopt_pkg::job_t head_job;
    logic [1:0]       q_count;
    logic [2:0]       back_idx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && job_valid;

    telopt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .rx_byte    (s_rx_byte),
        .job_valid  (job_valid),
        .job        (job)
    );

    telopt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head_job (head_job),
        .count    (q_count)
    );

    telopt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(q_not_empty),
        .head_job  (head_job),
        .pop       (pop),
        .idx       (back_idx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_kind(m_out_kind),
        .m_last    (m_last)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3)
        else $error("job queue count out of range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_not_empty)
        else $error("job popped from empty queue");

    a_job_in_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (back_idx != 3'd0) |-> q_not_empty)
        else $error("partial job lost from queue head");
`endif

endmodule
